[rtl/spd_pkg.sv]
// Shared types, constants and the flag decoder for the stylus packet decoder.
// Used by every module under rtl; depends on nothing else.
package spd_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned NumW   = 12;
  localparam int unsigned ProdW  = RawW + NumW;
  localparam int unsigned CntW   = $clog2(ProdW);
  localparam int unsigned PresW  = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned BufDepth = 6;
  localparam int unsigned PosW   = 3;

  localparam logic [PosW-1:0] LastPos = PosW'(BufDepth);

  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RAW_X_SPAN    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_RAW_Y_SPAN    = 2'd3;

  localparam logic [NumW-1:0] SCREEN_WIDTH_RST  = 12'd1280;
  localparam logic [RawW-1:0] RAW_X_SPAN_RST    = 16'd10206;
  localparam logic [NumW-1:0] SCREEN_HEIGHT_RST = 12'd800;
  localparam logic [RawW-1:0] RAW_Y_SPAN_RST    = 16'd7422;

  localparam logic [ByteW-1:0] FLAG_PEN_UP      = 8'ha0;
  localparam logic [ByteW-1:0] FLAG_PEN_DOWN    = 8'ha1;
  localparam logic [ByteW-1:0] FLAG_ERASER_UP   = 8'ha4;
  localparam logic [ByteW-1:0] FLAG_ERASER_DOWN = 8'ha5;
  localparam logic [ByteW-1:0] FLAG_ALL_LEAVE   = 8'he0;

  typedef enum logic [2:0] {
    EVT_NONE,
    EVT_PEN_DOWN,
    EVT_PEN_UP,
    EVT_ERASER_DOWN,
    EVT_ERASER_UP,
    EVT_ALL_LEAVE
  } evt_kind_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_DELIVER
  } top_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } scl_state_e;

  typedef struct packed {
    logic [RawW-1:0]  raw_x;
    logic [RawW-1:0]  raw_y;
    logic [PresW-1:0] pressure;
    logic [ByteW-1:0] flag;
  } frame_t;

  typedef struct packed {
    evt_kind_e kind;
    logic      touch;
  } evt_t;

  function automatic evt_t decode_flag(logic [ByteW-1:0] flag);
    evt_t r;
    case (flag)
      FLAG_PEN_DOWN: begin
        r.kind = EVT_PEN_DOWN;
        r.touch = 1'b1;
      end
      FLAG_PEN_UP: begin
        r.kind = EVT_PEN_UP;
        r.touch = 1'b0;
      end
      FLAG_ERASER_DOWN: begin
        r.kind = EVT_ERASER_DOWN;
        r.touch = 1'b1;
      end
      FLAG_ERASER_UP: begin
        r.kind = EVT_ERASER_UP;
        r.touch = 1'b0;
      end
      FLAG_ALL_LEAVE: begin
        r.kind = EVT_ALL_LEAVE;
        r.touch = 1'b0;
      end
      default: begin
        r.kind = EVT_NONE;
        r.touch = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/spd_frame.sv]
// Byte position tracking, report buffer and raw field assembly.
// Depends on spd_pkg.
module spd_frame import spd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             start_i,
  output logic             last_o,
  output frame_t           frame_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  pos_eff;
  logic [ByteW-1:0] buf_q [BufDepth];
  frame_t           frame_q, frame_d;

  assign pos_eff = start_i ? '0 : pos_q;
  assign last_o  = take_i && (pos_eff == LastPos);

  always_comb begin
    pos_d = pos_q;
    if (take_i) begin
      pos_d = (pos_eff == LastPos) ? '0 : pos_eff + 1'b1;
    end
  end

  always_comb begin
    frame_d.raw_x = {buf_q[1][6:0], 9'b0} | {6'b0, buf_q[2], 2'b0} | {13'b0, byte_i[7:5]};
    frame_d.raw_y = {buf_q[3][6:0], 9'b0} | {6'b0, buf_q[4], 2'b0} | {14'b0, byte_i[4:3]};
    frame_d.pressure = {byte_i[2:0], 7'b0} | {2'b0, buf_q[5]};
    frame_d.flag = buf_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && (pos_eff != LastPos)) begin
      buf_q[pos_eff] <= byte_i;
    end
    if (last_o) begin
      frame_q <= frame_d;
    end
  end

  assign frame_o = frame_q;

endmodule

[rtl/spd_scale.sv]
// Bit-serial scaler: shift-add multiply of raw by size, then restoring division
// by span in the same shift register. Depends on spd_pkg.
module spd_scale import spd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RawW-1:0] raw_i,
  input  logic [NumW-1:0] num_i,
  input  logic [RawW-1:0] span_i,
  output logic            done_o,
  output logic [RawW-1:0] quot_o
);

  localparam logic [CntW-1:0] MulLast = CntW'(NumW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(ProdW - 1);

  scl_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q;
  logic [ProdW-1:0] work_q, work_d;
  logic [RawW-1:0]  raw_q, span_q, rem_q, rem_d;
  logic             mul_step, div_step, finish;
  logic [RawW:0]    mul_sum, trial, diff;
  logic             fits;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        if (cnt_q == MulLast) begin
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        if (cnt_q == DivLast) begin
          state_d = SC_IDLE;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_comb begin
    mul_step = 1'b0;
    div_step = 1'b0;
    case (state_q)
      SC_MUL:  mul_step = 1'b1;
      SC_DIV:  div_step = 1'b1;
      default: ;
    endcase
    finish = div_step && (cnt_q == DivLast);
  end

  assign mul_sum = {1'b0, work_q[ProdW-1:NumW]} + (work_q[0] ? {1'b0, raw_q} : '0);
  assign trial   = {rem_q, work_q[ProdW-1]};
  assign fits    = trial >= {1'b0, span_q};
  assign diff    = trial - {1'b0, span_q};

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i && (state_q == SC_IDLE)) begin
      work_d = {{RawW{1'b0}}, num_i};
      rem_d  = '0;
      cnt_d  = '0;
    end else if (mul_step) begin
      work_d = {mul_sum, work_q[NumW-1:1]};
      cnt_d  = (cnt_q == MulLast) ? '0 : cnt_q + 1'b1;
    end else if (div_step) begin
      work_d = {work_q[ProdW-2:0], fits};
      rem_d  = fits ? diff[RawW-1:0] : trial[RawW-1:0];
      cnt_d  = finish ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (start_i && (state_q == SC_IDLE)) begin
      raw_q  <= raw_i;
      span_q <= span_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q[RawW-1:0];

endmodule

[rtl/stylus_packet_decoder.sv]
// Stylus packet decoder: takes a seven-byte pen report one byte per transaction
// and returns scaled X and Y, pressure and the decoded flag for each report.
// Bytes 0 to 5 are taken one per cycle. The seventh byte starts the serial
// scaler, a shift-add multiply and a restoring divide, run once for X and once
// for Y; the input stalls after the seventh byte until both results are loaded
// into the output register, and that load waits while the previous result is
// still held by the receiver. A finished result waits in the output register
// while the next report is collected.
// Depends on spd_pkg, spd_frame and spd_scale.
module stylus_packet_decoder import spd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   packet_byte_i,
  input  logic               packet_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RawW-1:0]    pos_x_o,
  output logic [RawW-1:0]    pos_y_o,
  output logic [PresW-1:0]   pen_pressure_o,
  output logic [2:0]         event_kind_o,
  output logic               touch_level_o,
  output logic [ByteW-1:0]   raw_flag_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  top_state_e      state_q, state_d;
  logic [NumW-1:0] scr_w_q, scr_h_q;
  logic [RawW-1:0] span_x_q, span_y_q;
  logic            take, frm_last;
  frame_t          frm;
  logic            scl_start, sel_y, scl_done;
  logic [RawW-1:0] scl_raw, scl_span, scl_quot;
  logic [NumW-1:0] scl_num;
  logic            cap_x, cap_y, out_load;
  logic [RawW-1:0] res_x_q, res_y_q;
  logic            out_valid_q;
  logic [RawW-1:0] pos_x_q, pos_y_q;
  logic [PresW-1:0] pres_q;
  evt_kind_e       kind_q;
  logic            touch_q;
  logic [ByteW-1:0] flag_q;
  evt_t            evt;

  assign take = in_valid_i && !in_stall_o;

  spd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (packet_byte_i),
    .start_i (packet_start_i),
    .last_o  (frm_last),
    .frame_o (frm)
  );

  assign scl_raw  = sel_y ? frm.raw_y : frm.raw_x;
  assign scl_num  = sel_y ? scr_h_q : scr_w_q;
  assign scl_span = sel_y ? span_y_q : span_x_q;

  spd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_start),
    .raw_i   (scl_raw),
    .num_i   (scl_num),
    .span_i  (scl_span),
    .done_o  (scl_done),
    .quot_o  (scl_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (frm_last) begin
          state_d = ST_START_X;
        end
      end
      ST_START_X: state_d = ST_WAIT_X;
      ST_WAIT_X: begin
        if (scl_done) begin
          state_d = ST_START_Y;
        end
      end
      ST_START_Y: state_d = ST_WAIT_Y;
      ST_WAIT_Y: begin
        if (scl_done) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    scl_start  = 1'b0;
    sel_y      = 1'b0;
    cap_x      = 1'b0;
    cap_y      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_COLLECT: in_stall_o = 1'b0;
      ST_START_X: scl_start = 1'b1;
      ST_WAIT_X:  cap_x = scl_done;
      ST_START_Y: begin
        scl_start = 1'b1;
        sel_y = 1'b1;
      end
      ST_WAIT_Y:  cap_y = scl_done;
      ST_DELIVER: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign evt = decode_flag(frm.flag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      out_valid_q <= 1'b0;
      scr_w_q     <= SCREEN_WIDTH_RST;
      span_x_q    <= RAW_X_SPAN_RST;
      scr_h_q     <= SCREEN_HEIGHT_RST;
      span_y_q    <= RAW_Y_SPAN_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCREEN_WIDTH:  scr_w_q  <= cfg_wdata_i[NumW-1:0];
          REG_RAW_X_SPAN:    span_x_q <= cfg_wdata_i[RawW-1:0];
          REG_SCREEN_HEIGHT: scr_h_q  <= cfg_wdata_i[NumW-1:0];
          REG_RAW_Y_SPAN:    span_y_q <= cfg_wdata_i[RawW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_x) begin
      res_x_q <= scl_quot;
    end
    if (cap_y) begin
      res_y_q <= scl_quot;
    end
    if (out_load) begin
      pos_x_q <= res_x_q;
      pos_y_q <= res_y_q;
      pres_q  <= frm.pressure;
      kind_q  <= evt.kind;
      touch_q <= evt.touch;
      flag_q  <= frm.flag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign pen_pressure_o = pres_q;
  assign event_kind_o   = kind_q;
  assign touch_level_o  = touch_q;
  assign raw_flag_o     = flag_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> (state_q == ST_WAIT_X || state_q == ST_WAIT_Y))
    else $error("Scaler finished outside a wait state.");

  a_last_starts_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_last |=> (state_q == ST_START_X && in_stall_o))
    else $error("Seventh byte did not start the X scaling.");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("Loaded result is not presented.");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for stylus_packet_decoder: streams pen report bytes under
// random flow control and register settings and checks every decoded report.
// Depends on rtl/spd_pkg.sv and the stylus_packet_decoder RTL.
module tb;
  import spd_pkg::*;

  localparam int unsigned MaxGap      = 13;
  localparam int unsigned HoldCycles  = 1000;
  localparam int unsigned HoldAfter   = 6;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned CycleLimit  = 300000;

  localparam logic [ByteW-1:0] FlagButtonA = 8'ha2;
  localparam logic [ByteW-1:0] FlagButtonB = 8'ha3;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             start;
  } pen_byte_t;

  typedef struct {
    logic [RawW-1:0]  x;
    logic [RawW-1:0]  y;
    logic [PresW-1:0] pressure;
    evt_kind_e        kind;
    logic             touch;
    logic [ByteW-1:0] flag;
  } pen_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   packet_byte = '0;
  logic               packet_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RawW-1:0]    pos_x;
  logic [RawW-1:0]    pos_y;
  logic [PresW-1:0]   pen_pressure;
  logic [2:0]         event_kind;
  logic               touch_level;
  logic [ByteW-1:0]   raw_flag;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  // Predictor state: register copies and the partial report.
  logic [NumW-1:0]  scr_w = SCREEN_WIDTH_RST;
  logic [RawW-1:0]  x_span = RAW_X_SPAN_RST;
  logic [NumW-1:0]  scr_h = SCREEN_HEIGHT_RST;
  logic [RawW-1:0]  y_span = RAW_Y_SPAN_RST;
  logic [PosW-1:0]  rpt_pos = '0;
  logic [ByteW-1:0] rpt_buf [BufDepth];

  pen_byte_t   pending_bytes [$];
  pen_report_t expected_reports [$];
  pen_byte_t   tx_item;
  pen_report_t seen_report;

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned reports_checked = 0;
  int unsigned settings_done = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  stylus_packet_decoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .packet_byte_i  (packet_byte),
    .packet_start_i (packet_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .pen_pressure_o (pen_pressure),
    .event_kind_o   (event_kind),
    .touch_level_o  (touch_level),
    .raw_flag_o     (raw_flag),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [RawW-1:0] scale_coord(logic [RawW-1:0] raw, logic [NumW-1:0] num,
                                                  logic [RawW-1:0] span);
    logic [31:0] quot;
    if (span == '0) return '1;
    quot = (32'(raw) * 32'(num)) / 32'(span);
    return quot[RawW-1:0];
  endfunction

  task automatic absorb_byte(input logic [ByteW-1:0] b, input logic start);
    logic [PosW-1:0] slot;
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
    pen_report_t     r;
    slot = start ? '0 : rpt_pos;
    if (slot < LastPos) begin
      rpt_buf[slot] = b;
      rpt_pos = slot + 1'b1;
    end else begin
      rpt_pos = '0;
      raw_x = {rpt_buf[1][6:0], 9'b0} | {6'b0, rpt_buf[2], 2'b0} | {13'b0, b[7:5]};
      raw_y = {rpt_buf[3][6:0], 9'b0} | {6'b0, rpt_buf[4], 2'b0} | {14'b0, b[4:3]};
      r.x = scale_coord(raw_x, scr_w, x_span);
      r.y = scale_coord(raw_y, scr_h, y_span);
      r.pressure = {b[2:0], 7'b0} | {2'b0, rpt_buf[5]};
      r.flag = rpt_buf[0];
      r.touch = 1'b0;
      case (rpt_buf[0])
        FLAG_PEN_DOWN: begin
          r.kind = EVT_PEN_DOWN;
          r.touch = 1'b1;
        end
        FLAG_PEN_UP:      r.kind = EVT_PEN_UP;
        FLAG_ERASER_DOWN: begin
          r.kind = EVT_ERASER_DOWN;
          r.touch = 1'b1;
        end
        FLAG_ERASER_UP:   r.kind = EVT_ERASER_UP;
        FLAG_ALL_LEAVE:   r.kind = EVT_ALL_LEAVE;
        default:          r.kind = EVT_NONE;
      endcase
      expected_reports.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Sender: one byte transaction at a time with a random gap before each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_byte(packet_byte, packet_start);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          tx_item = pending_bytes.pop_front();
          packet_byte <= tx_item.data;
          packet_start <= tx_item.start;
          in_valid <= 1'b1;
          tx_gap = draw_wait(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a random stall for every report, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_wait = draw_wait(rx_burst);
      end else if (out_valid && rx_wait != 0) begin
        rx_wait--;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && reports_checked >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      out_stall <= (hold_left != 0) || (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual x=%0h y=%0h p=%0h k=%0d t=%0b f=%0h",
                 $time, pos_x, pos_y, pen_pressure, event_kind, touch_level, raw_flag);
        errors++;
      end else begin
        seen_report = expected_reports.pop_front();
        check_field("pos_x", seen_report.x, pos_x);
        check_field("pos_y", seen_report.y, pos_y);
        check_field("pen_pressure", seen_report.pressure, pen_pressure);
        check_field("event_kind", seen_report.kind, event_kind);
        check_field("touch_level", seen_report.touch, touch_level);
        check_field("raw_flag", seen_report.flag, raw_flag);
      end
      reports_checked <= reports_checked + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = value[NumW-1:0];
      REG_RAW_X_SPAN:    x_span = value;
      REG_SCREEN_HEIGHT: scr_h = value[NumW-1:0];
      default:           y_span = value;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CfgW-1:0] sw, input logic [CfgW-1:0] xs,
                               input logic [CfgW-1:0] sh, input logic [CfgW-1:0] ys);
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_RAW_X_SPAN, xs);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_RAW_Y_SPAN, ys);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic queue_byte(input logic [ByteW-1:0] b, input logic start);
    pen_byte_t item;
    item.data = b;
    item.start = start;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic queue_report(input logic [ByteW-1:0] flag, input logic mark,
                              input int unsigned tail);
    queue_byte(flag, mark);
    repeat (tail) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic logic [ByteW-1:0] pick_flag();
    case ($urandom_range(0, 7))
      0:       return FLAG_PEN_UP;
      1:       return FLAG_PEN_DOWN;
      2:       return FLAG_ERASER_UP;
      3:       return FLAG_ERASER_DOWN;
      4:       return FLAG_ALL_LEAVE;
      5:       return FlagButtonA;
      6:       return FlagButtonB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly complete reports; the rest are cut short, unmarked or loose bytes.
  task automatic queue_random(input int unsigned count);
    int unsigned stop;
    stop = bytes_queued + count;
    while (bytes_queued < stop) begin
      case ($urandom_range(0, 9))
        7:       queue_report(pick_flag(), 1'b1, $urandom_range(0, 5));
        8:       repeat ($urandom_range(1, 8))
                   queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        9:       queue_report(pick_flag(), 1'b0, 6);
        default: queue_report(pick_flag(), 1'b1, 6);
      endcase
    end
  endtask

  task automatic settle();
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_byte(FLAG_PEN_DOWN, 1'b1);
    repeat (6) queue_byte(8'hff, 1'b0);
    queue_byte(FLAG_PEN_UP, 1'b0);
    repeat (6) queue_byte(8'h00, 1'b0);
    queue_report(FLAG_ERASER_DOWN, 1'b1, 3);
    queue_report(FLAG_ERASER_UP, 1'b1, 6);
    queue_random(150);
    settle();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       apply_setting(16'd4095, 16'd1, 16'd4095, 16'd1);
        1:       apply_setting(16'd1, 16'hffff, 16'd1, 16'hffff);
        2:       apply_setting(16'd0, 16'd123, 16'd4095, 16'd0);
        default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      @(negedge clk);
      queue_random(90);
      settle();
    end
    $display("Checked %0d reports from %0d byte transactions.", reports_checked, bytes_taken);
    $display("Covered reset registers and %0d written settings.", settings_done);
    if (errors == 0) begin
      $display("[stylus_packet_decoder] OK");
    end else begin
      $display("[stylus_packet_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles.", cycles);
    $display("[stylus_packet_decoder] ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/spd_pkg.sv
rtl/spd_frame.sv
rtl/spd_scale.sv
rtl/stylus_packet_decoder.sv
dv/tb.sv
